// File: rtl/ncc_pkg.sv
// shared types and constants of the stereo correlation disparity block
package ncc_pkg;

  // configuration port
  localparam int CFG_W     = 13;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RADIUS   = 3'd0,
    REG_MIN_DISP = 3'd1,
    REG_MAX_DISP = 3'd2,
    REG_WIDTH    = 3'd3,
    REG_HEIGHT   = 3'd4
  } cfg_reg_e;

  // register reset values
  localparam logic [2:0]  RST_RADIUS   = 3'd2;
  localparam logic [6:0]  RST_MIN_DISP = 7'd0;
  localparam logic [6:0]  RST_MAX_DISP = 7'd15;
  localparam logic [10:0] RST_WIDTH    = 11'd640;
  localparam logic [12:0] RST_HEIGHT   = 13'd480;

  // frame height limit and row counter width
  localparam int MAX_HEIGHT = 4096;
  localparam int HW         = 13;

  // input item kind
  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  // item as held in the queue between front and back
  typedef struct packed {
    logic       pixel;
    logic       sof;
    logic [7:0] left;
    logic [7:0] right;
  } item_t;

endpackage

// File: rtl/ncc_ram.sv
// generic single write port, single read port ram with registered read
module ncc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/ncc_front.sv
// input side: takes items, classifies them and queues them for the sequencer
module ncc_front import ncc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       in_kind_i,
  input  logic [7:0] in_left_pixel_i,
  input  logic [7:0] in_right_pixel_i,
  input  logic       in_start_of_frame_i,
  output logic       q_valid_o,
  output item_t      q_item_o,
  input  logic       q_pop_i
);

  item_t       fifo_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;
  item_t       item_in;

  // classify the incoming item
  always_comb begin
    item_in.pixel = (kind_e'(in_kind_i) == KIND_PIXEL);
    item_in.sof   = in_start_of_frame_i;
    item_in.left  = in_left_pixel_i;
    item_in.right = in_right_pixel_i;
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = fifo_q[rd_q];

  // pointer and fill update
  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = q_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= item_in;
    end
  end

endmodule

// File: rtl/ncc_back.sv
// sequencer: line stores, row scoring with a shared correlator, row buffer, output register
module ncc_back import ncc_pkg::*; #(
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_RADIUS     = 7,
  parameter int MAX_CANDIDATES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  item_t                q_item_i,
  output logic                 q_pop_o,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [7:0]    out_disparity_o,
  output logic                 out_end_of_row_o,
  output logic                 out_end_of_frame_o,
  output logic                 row_busy_o
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WCW   = CW + 1;
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int LINES = 2 * MAX_RADIUS + 1;
  localparam int SLW   = $clog2(LINES);
  localparam int LAW   = SLW + CW;
  localparam int ACC_W = 16 + $clog2(LINES * LINES);
  localparam int PW    = 2 * ACC_W;
  localparam int XW    = 3 * ACC_W;
  localparam int DW    = $clog2(64 + MAX_CANDIDATES) + 2;
  localparam int SPW   = ((CW > DW) ? CW : DW) + 3;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_POST   = 13'b0000000000010,
    S_XSTART = 13'b0000000000100,
    S_CAND   = 13'b0000000001000,
    S_ADDR   = 13'b0000000010000,
    S_MAC    = 13'b0000000100000,
    S_SQ     = 13'b0000001000000,
    S_M0     = 13'b0000010000000,
    S_M1     = 13'b0000100000000,
    S_SUM    = 13'b0001000000000,
    S_CMP    = 13'b0010000000000,
    S_NEXTD  = 13'b0100000000000,
    S_XEND   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [2:0]        rad_q;
  logic signed [6:0] mind_q, maxd_q;
  logic [10:0]       wid_q;
  logic [12:0]       hgt_q;
  logic              cfg_hit;

  // effective settings
  logic [RW-1:0]          r_eff;
  logic [SLW-1:0]         lines_eff;
  logic [WCW-1:0]         w_eff;
  logic [HW-1:0]          h_eff;
  logic signed [DW-1:0]   lo_d, hi_s, hi_cap, hi_eff;

  // frame position counters
  logic [WCW-1:0] icol_q, icol_d, ocol_q, ocol_d, icol_b, ocol_b, icol_n, ocol_n;
  logic [HW-1:0]  irow_q, irow_d, orow_q, orow_d, irow_b, orow_b;
  logic [SLW-1:0] islot_q, islot_d, oslot_q, oslot_d, islot_b, oslot_b;
  logic           rdy_q, rdy_d, rdy_b, restart_now, emit_now;
  logic           emit_q, emit_d, eor_q, eor_d, eof_q, eof_d;
  logic [HW:0]    need_sum, need;

  // row scoring datapath
  logic [WCW-1:0]        x_q, x_d;
  logic signed [DW-1:0]  d_q, d_d, best_q, best_d;
  logic                  found_q, found_d;
  logic [SLW-1:0]        j_q, j_d, slot_q, slot_d, slot_init;
  logic signed [RW:0]    i_q, i_d, r_s;
  logic signed [HW:0]    t_q, t_d, t_init, t_n;
  logic [SLW:0]          slot_sum;
  logic [ACC_W-1:0]      corr_q, corr_d, en_q, en_d, den_q, den_d, bden_q, bden_d;
  logic [PW-1:0]         num_q, num_d, bnum_q, bnum_d, sq;
  logic [PW-1:0]         pal_q, pal_d, pbl_q, pbl_d, pah_q, pah_d, pbh_q, pbh_d;
  logic [XW-1:0]         a_q, a_d, b_q, b_d;
  logic signed [SPW-1:0] x_s, d_s, i_s, w_s, xd, xl, xr;
  logic [CW-1:0]         col_l, col_r;
  logic [15:0]           prod_lr, prod_rr;

  // output register
  logic                 out_valid_q, out_valid_d, out_eor_q, out_eor_d, out_eof_q, out_eof_d;
  logic signed [7:0]    out_disp_q, out_disp_d;

  // memory ports
  logic           line_we, rb_we;
  logic [LAW-1:0] line_waddr, line_raddr_l, line_raddr_r;
  logic [7:0]     left_rd, right_rd, rb_rdata, rb_wdata;
  logic [CW-1:0]  rb_waddr, rb_raddr;

  ncc_ram #(.WIDTH(8), .DEPTH(LINES << CW)) u_left_store (
    .clk_i  (clk_i),
    .we_i   (line_we),
    .waddr_i(line_waddr),
    .wdata_i(q_item_i.left),
    .raddr_i(line_raddr_l),
    .rdata_o(left_rd)
  );

  ncc_ram #(.WIDTH(8), .DEPTH(LINES << CW)) u_right_store (
    .clk_i  (clk_i),
    .we_i   (line_we),
    .waddr_i(line_waddr),
    .wdata_i(q_item_i.right),
    .raddr_i(line_raddr_r),
    .rdata_o(right_rd)
  );

  ncc_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_row_buf (
    .clk_i  (clk_i),
    .we_i   (rb_we),
    .waddr_i(rb_waddr),
    .wdata_i(rb_wdata),
    .raddr_i(rb_raddr),
    .rdata_o(rb_rdata)
  );

  // effective register values
  always_comb begin
    if (32'(rad_q) > MAX_RADIUS) begin
      r_eff = RW'(MAX_RADIUS);
    end else begin
      r_eff = RW'(rad_q);
    end
    lines_eff = SLW'({r_eff, 1'b1});
    if (wid_q == '0) begin
      w_eff = WCW'(1);
    end else if (32'(wid_q) > MAX_WIDTH) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(wid_q);
    end
    if (hgt_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(hgt_q) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = hgt_q;
    end
    lo_d   = DW'(mind_q);
    hi_s   = DW'(maxd_q);
    hi_cap = lo_d + $signed(DW'(MAX_CANDIDATES - 1));
    hi_eff = (hi_s > hi_cap) ? hi_cap : hi_s;
  end

  // positions after a start of frame on the item at the head of the queue
  always_comb begin
    restart_now = q_item_i.pixel && q_item_i.sof;
    icol_b  = restart_now ? '0 : icol_q;
    irow_b  = restart_now ? '0 : irow_q;
    islot_b = restart_now ? '0 : islot_q;
    ocol_b  = restart_now ? '0 : ocol_q;
    orow_b  = restart_now ? '0 : orow_q;
    oslot_b = restart_now ? '0 : oslot_q;
    rdy_b   = restart_now ? 1'b0 : rdy_q;
    emit_now = rdy_b && (ocol_b < w_eff) && (orow_b < h_eff);
    icol_n  = icol_b + WCW'(1);
    ocol_n  = ocol_b + WCW'(1);
  end

  // last input row that output row needs
  always_comb begin
    need_sum = (HW+1)'(orow_q) + (HW+1)'(r_eff);
    need     = (need_sum > (HW+1)'(h_eff - HW'(1))) ? (HW+1)'(h_eff - HW'(1)) : need_sum;
  end

  // window coordinates and clamped columns
  always_comb begin
    x_s = SPW'(x_q);
    d_s = SPW'(d_q);
    i_s = SPW'(i_q);
    w_s = SPW'(w_eff);
    xd  = x_s + d_s;
    xl  = x_s + i_s;
    xr  = xd + i_s;
    if (xl < 0) begin
      col_l = '0;
    end else if (xl >= w_s) begin
      col_l = CW'(w_eff - WCW'(1));
    end else begin
      col_l = xl[CW-1:0];
    end
    if (xr < 0) begin
      col_r = '0;
    end else if (xr >= w_s) begin
      col_r = CW'(w_eff - WCW'(1));
    end else begin
      col_r = xr[CW-1:0];
    end
  end

  // first window row and its line store slot
  always_comb begin
    r_s      = $signed({1'b0, r_eff});
    t_init   = $signed((HW+1)'(orow_q)) - $signed((HW+1)'(r_eff));
    t_n      = t_q + $signed((HW+1)'(1));
    if (oslot_q >= SLW'(r_eff)) begin
      slot_sum = (SLW+1)'(oslot_q) - (SLW+1)'(r_eff);
    end else begin
      slot_sum = (SLW+1)'(oslot_q) + (SLW+1)'(lines_eff) - (SLW+1)'(r_eff);
    end
    slot_init = t_init[HW] ? '0 : slot_sum[SLW-1:0];
  end

  // correlator products
  assign prod_lr = left_rd * right_rd;
  assign prod_rr = right_rd * right_rd;
  assign sq      = corr_q * corr_q;

  assign cfg_hit = cfg_we_i && (cfg_index_i <= REG_HEIGHT);

  // sequencer
  always_comb begin
    state_d = state_q;
    icol_d = icol_q; irow_d = irow_q; islot_d = islot_q;
    ocol_d = ocol_q; orow_d = orow_q; oslot_d = oslot_q; rdy_d = rdy_q;
    emit_d = emit_q; eor_d = eor_q; eof_d = eof_q;
    x_d = x_q; d_d = d_q; found_d = found_q; best_d = best_q;
    j_d = j_q; i_d = i_q; t_d = t_q; slot_d = slot_q;
    corr_d = corr_q; en_d = en_q; num_d = num_q; den_d = den_q;
    bnum_d = bnum_q; bden_d = bden_q;
    pal_d = pal_q; pbl_d = pbl_q; pah_d = pah_q; pbh_d = pbh_q;
    a_d = a_q; b_d = b_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_disp_d = out_disp_q; out_eor_d = out_eor_q; out_eof_d = out_eof_q;
    q_pop_o = 1'b0;
    line_we = 1'b0;
    line_waddr = {islot_b, icol_b[CW-1:0]};
    line_raddr_l = {slot_q, col_l};
    line_raddr_r = {slot_q, col_r};
    rb_we = 1'b0;
    rb_waddr = x_q[CW-1:0];
    rb_wdata = found_q ? best_q[7:0] : 8'd0;
    rb_raddr = ocol_b[CW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && (!out_valid_q || !out_stall_i)) begin
          q_pop_o = 1'b0 | 1'b1;
          // emit one buffered disparity
          emit_d = emit_now;
          eor_d  = (ocol_b == w_eff - WCW'(1));
          eof_d  = (ocol_b == w_eff - WCW'(1)) && (orow_b == h_eff - HW'(1));
          ocol_d = ocol_b; orow_d = orow_b; oslot_d = oslot_b; rdy_d = rdy_b;
          if (emit_now) begin
            if (ocol_n >= w_eff) begin
              ocol_d  = '0;
              orow_d  = orow_b + HW'(1);
              oslot_d = (oslot_b == lines_eff - SLW'(1)) ? '0 : oslot_b + SLW'(1);
              rdy_d   = 1'b0;
            end else begin
              ocol_d = ocol_n;
            end
          end
          // store the pixel pair
          icol_d = icol_b; irow_d = irow_b; islot_d = islot_b;
          if (q_item_i.pixel && (irow_b < h_eff) && (icol_b < w_eff)) begin
            line_we = 1'b1;
            if (icol_n >= w_eff) begin
              icol_d  = '0;
              irow_d  = irow_b + HW'(1);
              islot_d = (islot_b == lines_eff - SLW'(1)) ? '0 : islot_b + SLW'(1);
            end else begin
              icol_d = icol_n;
            end
          end
          state_d = S_POST;
        end
      end
      S_POST: begin
        if (emit_q) begin
          out_valid_d = 1'b1;
          out_disp_d  = $signed(rb_rdata);
          out_eor_d   = eor_q;
          out_eof_d   = eof_q;
        end
        emit_d = 1'b0;
        // start a row once its window rows are all in
        if (!rdy_q && (orow_q < h_eff) && ((HW+1)'(irow_q) > need)) begin
          x_d     = '0;
          state_d = S_XSTART;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_XSTART: begin
        d_d     = lo_d;
        found_d = 1'b0;
        state_d = (lo_d > hi_eff) ? S_XEND : S_CAND;
      end
      S_CAND: begin
        if ((xd < 0) || (xd >= w_s)) begin
          state_d = S_NEXTD;
        end else begin
          corr_d  = '0;
          en_d    = '0;
          j_d     = '0;
          i_d     = -r_s;
          t_d     = t_init;
          slot_d  = slot_init;
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        state_d = S_MAC;
      end
      S_MAC: begin
        corr_d = corr_q + ACC_W'(prod_lr);
        en_d   = en_q + ACC_W'(prod_rr);
        if (i_q == r_s) begin
          i_d = -r_s;
          if (j_q == SLW'({r_eff, 1'b0})) begin
            state_d = S_SQ;
          end else begin
            j_d = j_q + SLW'(1);
            t_d = t_n;
            // window row steps down, held at the image edges
            if (t_n[HW] || (t_n == '0)) begin
              slot_d = '0;
            end else if (t_n[HW-1:0] >= h_eff) begin
              slot_d = slot_q;
            end else begin
              slot_d = (slot_q == lines_eff - SLW'(1)) ? '0 : slot_q + SLW'(1);
            end
            state_d = S_ADDR;
          end
        end else begin
          i_d     = i_q + $signed((RW+1)'(1));
          state_d = S_ADDR;
        end
      end
      S_SQ: begin
        if (en_q == '0) begin
          num_d = '0;
          den_d = ACC_W'(1);
        end else begin
          num_d = sq;
          den_d = en_q;
        end
        state_d = S_M0;
      end
      S_M0: begin
        if (!found_q) begin
          found_d = 1'b1;
          best_d  = d_q;
          bnum_d  = num_q;
          bden_d  = den_q;
          state_d = S_NEXTD;
        end else begin
          pal_d   = num_q[ACC_W-1:0] * bden_q;
          pbl_d   = bnum_q[ACC_W-1:0] * den_q;
          state_d = S_M1;
        end
      end
      S_M1: begin
        pah_d   = num_q[PW-1:ACC_W] * bden_q;
        pbh_d   = bnum_q[PW-1:ACC_W] * den_q;
        state_d = S_SUM;
      end
      S_SUM: begin
        a_d     = (XW'(pah_q) << ACC_W) + XW'(pal_q);
        b_d     = (XW'(pbh_q) << ACC_W) + XW'(pbl_q);
        state_d = S_CMP;
      end
      S_CMP: begin
        // strictly better keeps the first maximum
        if (a_q > b_q) begin
          best_d = d_q;
          bnum_d = num_q;
          bden_d = den_q;
        end
        state_d = S_NEXTD;
      end
      S_NEXTD: begin
        if (d_q == hi_eff) begin
          state_d = S_XEND;
        end else begin
          d_d     = d_q + $signed(DW'(1));
          state_d = S_CAND;
        end
      end
      S_XEND: begin
        rb_we = 1'b1;
        if (x_q == w_eff - WCW'(1)) begin
          rdy_d   = 1'b1;
          ocol_d  = '0;
          state_d = S_IDLE;
        end else begin
          x_d     = x_q + WCW'(1);
          state_d = S_XSTART;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a register write abandons the frame
    if (cfg_hit) begin
      icol_d = '0; irow_d = '0; islot_d = '0;
      ocol_d = '0; orow_d = '0; oslot_d = '0;
      rdy_d  = 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= RST_RADIUS;
      mind_q <= $signed(RST_MIN_DISP);
      maxd_q <= $signed(RST_MAX_DISP);
      wid_q  <= RST_WIDTH;
      hgt_q  <= RST_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_RADIUS:   rad_q  <= cfg_data_i[2:0];
        REG_MIN_DISP: mind_q <= $signed(cfg_data_i[6:0]);
        REG_MAX_DISP: maxd_q <= $signed(cfg_data_i[6:0]);
        REG_WIDTH:    wid_q  <= cfg_data_i[10:0];
        REG_HEIGHT:   hgt_q  <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      icol_q      <= '0;
      irow_q      <= '0;
      islot_q     <= '0;
      ocol_q      <= '0;
      orow_q      <= '0;
      oslot_q     <= '0;
      rdy_q       <= 1'b0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      icol_q      <= icol_d;
      irow_q      <= irow_d;
      islot_q     <= islot_d;
      ocol_q      <= ocol_d;
      orow_q      <= orow_d;
      oslot_q     <= oslot_d;
      rdy_q       <= rdy_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    eor_q     <= eor_d;
    eof_q     <= eof_d;
    x_q       <= x_d;
    d_q       <= d_d;
    found_q   <= found_d;
    best_q    <= best_d;
    j_q       <= j_d;
    i_q       <= i_d;
    t_q       <= t_d;
    slot_q    <= slot_d;
    corr_q    <= corr_d;
    en_q      <= en_d;
    num_q     <= num_d;
    den_q     <= den_d;
    bnum_q    <= bnum_d;
    bden_q    <= bden_d;
    pal_q     <= pal_d;
    pbl_q     <= pbl_d;
    pah_q     <= pah_d;
    pbh_q     <= pbh_d;
    a_q       <= a_d;
    b_q       <= b_d;
    out_disp_q <= out_disp_d;
    out_eor_q <= out_eor_d;
    out_eof_q <= out_eof_d;
  end

  assign out_valid_o        = out_valid_q;
  assign out_disparity_o    = out_disp_q;
  assign out_end_of_row_o   = out_eor_q;
  assign out_end_of_frame_o = out_eof_q;
  assign row_busy_o         = (state_q != S_IDLE) && (state_q != S_POST);

endmodule

// File: rtl/stereo_ncc_disparity.sv
// top level of the stereo correlation disparity block
// Rectified left/right pixel pairs enter in raster order and one disparity item leaves for each
// input item once a row of results is buffered. Items pass a two-entry queue into a sequencer
// that takes an item in S_IDLE and finishes it in S_POST. When the input rows for output row y
// are complete (input row min(y+R, H-1)), the sequencer scores the whole row before it takes the
// next item: per column S_XSTART and S_XEND, per candidate disparity S_CAND and S_NEXTD, and if
// x+d lies inside the image S_ADDR and S_MAC per window pixel, S_SQ, and the root-free score
// compare in S_M0, S_M1, S_SUM and S_CMP on two narrow multipliers (the first candidate inside
// skips the compare after S_M0). The single multiply-accumulate unit, fed by one read port of
// each line store, bounds the scoring. Input stalls once the queue fills while a row is scored.
module stereo_ncc_disparity import ncc_pkg::*; #(
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_RADIUS     = 7,
  parameter int MAX_CANDIDATES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 in_kind_i,
  input  logic [7:0]           in_left_pixel_i,
  input  logic [7:0]           in_right_pixel_i,
  input  logic                 in_start_of_frame_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [7:0]    out_disparity_o,
  output logic                 out_end_of_row_o,
  output logic                 out_end_of_frame_o,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic  q_valid, q_pop, row_busy;
  item_t q_item;

  // input queue
  ncc_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_kind_i          (in_kind_i),
    .in_left_pixel_i    (in_left_pixel_i),
    .in_right_pixel_i   (in_right_pixel_i),
    .in_start_of_frame_i(in_start_of_frame_i),
    .q_valid_o          (q_valid),
    .q_item_o           (q_item),
    .q_pop_i            (q_pop)
  );

  // sequencer and scoring
  ncc_back #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_RADIUS    (MAX_RADIUS),
    .MAX_CANDIDATES(MAX_CANDIDATES)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_item_i          (q_item),
    .q_pop_o           (q_pop),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_disparity_o   (out_disparity_o),
    .out_end_of_row_o  (out_end_of_row_o),
    .out_end_of_frame_o(out_end_of_frame_o),
    .row_busy_o        (row_busy)
  );

  // a result is never launched from inside a row computation
  a_rise_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(row_busy))
    else $error("result launched during row scoring");

  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_busy && !out_valid_o |=> !out_valid_o)
    else $error("result appeared while scoring a row");

  // end of frame only on the last item of a row
  a_eof_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_end_of_frame_o |-> out_end_of_row_o)
    else $error("end of frame without end of row");

endmodule

// File: tb/stereo_ncc_disparity_check.sv
// checker for the stereo disparity block: predicts every disparity item and compares
`timescale 1ns / 1ps

module stereo_ncc_disparity_check import ncc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 in_kind_i,
  input  logic [7:0]           in_left_pixel_i,
  input  logic [7:0]           in_right_pixel_i,
  input  logic                 in_start_of_frame_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic signed [7:0]    out_disparity_i,
  input  logic                 out_end_of_row_i,
  input  logic                 out_end_of_frame_i,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   pending_o,
  output int                   fails_o
);

  localparam int LINE = 1024;
  localparam int SLOTS = 15;

  typedef struct {
    logic signed [7:0] disp;
    logic              eor;
    logic              eof;
  } disp_item_t;

  disp_item_t disp_q[$];

  // register copies
  logic [2:0]  radius;
  logic [6:0]  dmin, dmax;
  logic [10:0] width;
  logic [12:0] height;

  // line stores, positions and the buffered row of disparities
  logic [7:0] left_store [0:SLOTS*LINE-1];
  logic [7:0] right_store [0:SLOTS*LINE-1];
  logic [7:0] row_disp [0:LINE-1];
  int in_col, in_row, out_col, out_row;
  bit row_ready;

  function automatic int eff_w();
    return (width == 0) ? 1 : ((width > LINE) ? LINE : int'(width));
  endfunction

  function automatic int eff_h();
    return (height == 0) ? 1 : ((height > MAX_HEIGHT) ? MAX_HEIGHT : int'(height));
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // true when na/da exceeds nb/db, compared by cross products
  function automatic bit score_wins(longint unsigned na, longint unsigned da,
                                    longint unsigned nb, longint unsigned db);
    logic [127:0] lhs, rhs;
    lhs = {64'd0, na} * {64'd0, db};
    rhs = {64'd0, nb} * {64'd0, da};
    return lhs > rhs;
  endfunction

  // winning disparity of one column by normalized cross-correlation
  function automatic int match_column(int x, int y);
    int r, w, h, lines, lo, hi, d, j, i, best, li, ri;
    int rowbase [0:SLOTS-1];
    bit found;
    longint unsigned corr, energy, num, den, best_num, best_den;
    r = radius;
    w = eff_w();
    h = eff_h();
    lines = 2 * r + 1;
    lo = $signed(dmin);
    hi = $signed(dmax);
    best = 0;
    found = 0;
    best_num = 0;
    best_den = 1;
    if (hi - lo + 1 > 64) hi = lo + 63;
    for (j = 0; j < lines; j++) rowbase[j] = (clip(y + j - r, 0, h - 1) % lines) * LINE;
    for (d = lo; d <= hi; d++) begin
      if (x + d < 0 || x + d >= w) continue;
      corr = 0;
      energy = 0;
      for (j = 0; j < lines; j++) begin
        for (i = -r; i <= r; i++) begin
          li = rowbase[j] + clip(x + i, 0, w - 1);
          ri = rowbase[j] + clip(x + d + i, 0, w - 1);
          corr += left_store[li] * right_store[ri];
          energy += right_store[ri] * right_store[ri];
        end
      end
      num = corr * corr;
      den = energy;
      if (den == 0) begin
        num = 0;
        den = 1;
      end
      if (!found || score_wins(num, den, best_num, best_den)) begin
        found = 1;
        best = d;
        best_num = num;
        best_den = den;
      end
    end
    return best;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    row_ready = 0;
  endfunction

  // one accepted input item: emit, store, then score a row when its inputs are in
  function automatic void take_item(logic kind, logic [7:0] lp, logic [7:0] rp, logic sof);
    bit px;
    int w, h, r, need, x;
    disp_item_t e;
    px = (kind == KIND_PIXEL);
    w = eff_w();
    h = eff_h();
    r = radius;
    if (px && sof) restart_frame();
    if (row_ready && out_col < w && out_row < h) begin
      e.disp = row_disp[out_col];
      e.eor = (out_col == w - 1);
      e.eof = e.eor && (out_row == h - 1);
      disp_q.push_back(e);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
        row_ready = 0;
      end
    end
    if (px && in_row < h && in_col < w) begin
      left_store[(in_row % (2 * r + 1)) * LINE + in_col] = lp;
      right_store[(in_row % (2 * r + 1)) * LINE + in_col] = rp;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
    if (!row_ready && out_row < h) begin
      need = (out_row + r > h - 1) ? h - 1 : out_row + r;
      if (in_row > need) begin
        for (x = 0; x < w; x++) row_disp[x] = 8'(match_column(x, out_row));
        out_col = 0;
        row_ready = 1;
      end
    end
  endfunction

  initial begin
    radius = RST_RADIUS;
    dmin = RST_MIN_DISP;
    dmax = RST_MAX_DISP;
    width = RST_WIDTH;
    height = RST_HEIGHT;
    restart_frame();
  end

  assign pending_o = disp_q.size();

  // inputs change only at rising edges, so the values at the falling edge are the
  // ones taken at the next rising edge
  always @(negedge clk_i) begin
    disp_item_t e;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_RADIUS:   radius = cfg_data_i[2:0];
          REG_MIN_DISP: dmin = cfg_data_i[6:0];
          REG_MAX_DISP: dmax = cfg_data_i[6:0];
          REG_WIDTH:    width = cfg_data_i[10:0];
          REG_HEIGHT:   height = cfg_data_i[12:0];
          default: ;
        endcase
        if (cfg_index_i <= REG_HEIGHT) restart_frame();
      end
      if (in_valid_i && !in_stall_i)
        take_item(in_kind_i, in_left_pixel_i, in_right_pixel_i, in_start_of_frame_i);
      if (out_valid_i && !out_stall_i) begin
        if (disp_q.size() == 0) begin
          $error("disparity item with nothing expected: %0d", out_disparity_i);
          fails_o++;
        end else begin
          e = disp_q.pop_front();
          if (out_disparity_i !== e.disp) begin
            $error("disparity expected %0d actual %0d", e.disp, out_disparity_i);
            fails_o++;
          end
          if (out_end_of_row_i !== e.eor) begin
            $error("end_of_row expected %0d actual %0d", e.eor, out_end_of_row_i);
            fails_o++;
          end
          if (out_end_of_frame_i !== e.eof) begin
            $error("end_of_frame expected %0d actual %0d", e.eof, out_end_of_frame_i);
            fails_o++;
          end
        end
      end
    end
  end

endmodule

// File: tb/stereo_ncc_disparity_test.sv
// testbench top for the stereo disparity block: stimulus, idling and verdict
`timescale 1ns / 1ps

module stereo_ncc_disparity_test;
  import ncc_pkg::*;

  localparam int CYCLE_LIMIT = 8_000_000;

  logic                 clk_i, rst_ni;
  logic                 in_valid_i, in_stall_o, in_kind_i, in_start_of_frame_i;
  logic [7:0]           in_left_pixel_i, in_right_pixel_i;
  logic                 out_valid_o, out_stall_i, out_end_of_row_o, out_end_of_frame_o;
  logic signed [7:0]    out_disparity_o;
  logic                 cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  int                   pending, fails, cycles, item_cnt, send_idle, recv_idle;

  // current register values, for the idle pause
  int cur_r, cur_min, cur_max, cur_w;

  stereo_ncc_disparity u_top (.*);

  stereo_ncc_disparity_check u_check (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_kind_i,
    .in_left_pixel_i, .in_right_pixel_i, .in_start_of_frame_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_disparity_i(out_disparity_o),
    .out_end_of_row_i(out_end_of_row_o), .out_end_of_frame_i(out_end_of_frame_o),
    .cfg_we_i, .cfg_index_i, .cfg_data_i, .pending_o(pending), .fails_o(fails)
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver stalls and the run limit
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // worst time to score one row under the current registers
  function automatic int row_latency();
    int c, w, win;
    c = cur_max - cur_min + 1;
    if (c > 64) c = 64;
    if (c < 1) c = 1;
    w = (cur_w == 0) ? 1 : ((cur_w > 1024) ? 1024 : cur_w);
    win = 2 * cur_r + 1;
    return w * (2 + c * (2 * win * win + 7)) + 64;
  endfunction

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (row_latency()) @(posedge clk_i);
  endtask

  // idling modes follow progress through the run
  task automatic set_mode();
    if (item_cnt < 200) begin
      send_idle = 34;
      recv_idle = 80;
    end else if (item_cnt < 400) begin
      send_idle = 80;
      recv_idle = 34;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  endtask

  task automatic send(logic kind, logic [7:0] lp, logic [7:0] rp, logic sof);
    bit ok;
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_kind_i <= kind;
    in_left_pixel_i <= lp;
    in_right_pixel_i <= rp;
    in_start_of_frame_i <= sof;
    do begin
      @(negedge clk_i);
      ok = !in_stall_o;
      @(posedge clk_i);
    end while (!ok);
    item_cnt++;
    set_mode();
  endtask

  // registers carry random upper bits that the block must ignore
  task automatic set_config(int r, int dmin, int dmax, int w, int h);
    int vals [5];
    int masks [5];
    wait_idle();
    vals = '{r, dmin, dmax, w, h};
    masks = '{'h7, 'h7f, 'h7f, 'h7ff, 'h1fff};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= cfg_reg_e'(i);
      cfg_data_i <= CFG_W'(($urandom & ~masks[i]) | (vals[i] & masks[i]));
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_r = r;
    cur_min = $signed(7'(dmin));
    cur_max = $signed(7'(dmax));
    cur_w = w & 'h7ff;
  endtask

  // pixel patterns: 0 random, 1 dark right image, 2 flat, 3 full-scale checker
  function automatic logic [7:0] pick(int pat, int p, bit right);
    case (pat)
      1: return right ? 8'd0 : 8'($urandom);
      2: return 8'd100;
      3: return ((p + right) % 2) ? 8'd255 : 8'd0;
      default: return 8'($urandom);
    endcase
  endfunction

  // one frame; cut stops early, noise mixes in flushes and stray start flags,
  // extra adds pixels past the frame without a start flag
  task automatic run_frame(int r, int dmin, int dmax, int w, int h, int pat, int cut,
                           bit noise, bit extra);
    int n, ew, eh;
    set_config(r, dmin, dmax, w, h);
    ew = (w == 0) ? 1 : ((w > 1024) ? 1024 : w);
    eh = (h == 0) ? 1 : ((h > 4096) ? 4096 : h);
    n = (cut > 0) ? cut : ew * eh;
    for (int p = 0; p < n; p++) begin
      if (noise && $urandom_range(0, 9) == 0)
        send(KIND_FLUSH, 8'($urandom), 8'($urandom), 1'($urandom));
      send(KIND_PIXEL, pick(pat, p, 0), pick(pat, p, 1), p == 0);
    end
    if (extra)
      repeat ($urandom_range(1, 4)) send(KIND_PIXEL, 8'($urandom), 8'($urandom), 1'b0);
    if (cut == 0)
      repeat (ew * ((eh < r + 2 ? eh : r + 2) + 1))
        send(KIND_FLUSH, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  initial begin
    int r, lo, hi;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_kind_i = KIND_PIXEL;
    in_left_pixel_i = '0;
    in_right_pixel_i = '0;
    in_start_of_frame_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_RADIUS;
    cfg_data_i = '0;
    item_cnt = 0;
    cur_r = RST_RADIUS;
    cur_min = 0;
    cur_max = RST_MAX_DISP;
    cur_w = RST_WIDTH;
    set_mode();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // a few pixels under the reset registers
    for (int p = 0; p < 5; p++) send(KIND_PIXEL, 8'($urandom), 8'($urandom), p == 0);

    // directed: widest window, all candidates, empty range, dark right image,
    // ties, single pixel with dropped extras, long row, clamped sizes
    run_frame(7, 0, 1, 3, 2, 3, 0, 0, 0);
    run_frame(0, -64, 63, 4, 1, 0, 0, 0, 0);
    run_frame(1, 3, -3, 4, 2, 0, 0, 0, 0);
    run_frame(1, -2, 2, 5, 3, 1, 0, 0, 0);
    run_frame(1, 0, 3, 4, 2, 2, 0, 0, 0);
    run_frame(2, -1, 1, 0, 0, 0, 0, 1, 1);
    run_frame(0, 0, 0, 64, 1, 0, 0, 0, 0);
    run_frame(0, 0, 0, 2047, 8191, 0, 6, 0, 0);
    run_frame(0, 0, 1, 1, 4096, 0, 10, 0, 0);
    run_frame(1, -3, 3, 4, 3, 0, 4, 0, 0);

    // random frames of small size, now and then broken or noisy
    while (item_cnt < 500) begin
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 7) : $urandom_range(0, 2);
      lo = $urandom_range(0, 9) - 5;
      hi = lo + $urandom_range(0, 6) - 1;
      run_frame(r, lo, hi, $urandom_range(1, 10), $urandom_range(1, 5),
                ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0,
                ($urandom_range(0, 6) == 0) ? $urandom_range(1, 12) : 0,
                $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
    end

    wait_idle();
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
